### rtl/assert_macros.svh
// Assertion macros used by the sampler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PMS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PMS_ASSERT(lbl, clk, rst_n, prop)
`define PMS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/pms_pkg.sv
// Constants and types of the polyline marker sampler.
package pms_pkg;
  localparam int MAX_MARKERS    = 4096;
  localparam int MAX_POLY_VERTS = 64;
  localparam int MAX_OBSTACLES  = 64;
  localparam int MAX_SEGMENTS   = 63;
  localparam int FRAC_BITS      = 16;

  localparam int CRD_W  = 32;
  localparam int GRID_W = 31;
  localparam int IDX_W  = 12;
  localparam int DIF_W  = CRD_W + 1;
  localparam int SQ_W   = 2 * DIF_W;
  localparam int LEN_W  = DIF_W;
  localparam int MK_W   = $clog2(MAX_MARKERS + 1);
  localparam int VP_W   = $clog2(MAX_POLY_VERTS + 1);
  localparam int PC_W   = $clog2(MAX_OBSTACLES + 1);
  localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int NB_W   = $clog2(SEG_W);
  localparam int SATW   = GRID_W + SEG_W;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic [DIF_W-1:0] q;
    logic [SEG_W-1:0] r;
  } div_lane_t;
endpackage

### rtl/polyline_marker_sampler.sv
// Polyline marker sampler: top level with vertex bookkeeping and sequencer.
// After a vertex beat it squares and sums the offsets, takes the square root, finds the
// segment count (skipped when it saturates) and divides the step, then takes one step
// per cycle while the output can take a marker. No new vertex is taken until it is back
// in S_IDLE; a vertex that forms no edge leaves it there. The root and divider dominate.
// Reset (rst_n low, synchronous) clears vertex, obstacle and marker counts, prev vertex
// and the output valid flag, and sets grid_spacing to 1.0; no clearing pass is needed.
module polyline_marker_sampler
  import pms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,     // grid_spacing
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // vertex_x [31:0], vertex_y [63:32]
  input  logic [1:0]  in_tuser,      // starts_polyline [0], starts_pass [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,     // marker_x [31:0], marker_y [63:32],
                                     // marker_index [75:64], zero [79:76]
  output logic        out_tlast      // last_of_run
);
`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SQR, S_SUM, S_ROOT, S_NDIV, S_QSTART, S_QDIV, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [GRID_W-1:0]   grid_r, grid_nxt;
  logic [CRD_W-1:0]    prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [VP_W-1:0]     vip_r, vip_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic                pa_r, pa_nxt;
  logic [MK_W-1:0]     me_r, me_nxt;
  logic                st_r, st_nxt;
  // edge operands
  logic [DIF_W-1:0]    ax_r, ax_nxt, ay_r, ay_nxt;
  logic                negx_r, negx_nxt, negy_r, negy_nxt;
  logic [CRD_W-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic                first_r, first_nxt;
  logic [SQ_W-1:0]     sx_r, sx_nxt, sy_r, sy_nxt;
  // segment count
  logic [SEG_W-1:0]    n_r, n_nxt, nq_r, nq_nxt;
  logic [LEN_W:0]      nrem_r, nrem_nxt;
  logic [NB_W-1:0]     nbit_r, nbit_nxt;
  // marker stepping
  logic [SEG_W-1:0]    s_r, s_nxt;
  logic [DIF_W-1:0]    qx_r, qx_nxt, qy_r, qy_nxt;
  logic [SEG_W-1:0]    rx_r, rx_nxt, ry_r, ry_nxt;
  // output register
  logic                ov_r, ov_nxt, ol_r, ol_nxt;
  logic [CRD_W-1:0]    ox_r, ox_nxt, oy_r, oy_nxt;
  logic [IDX_W-1:0]    oi_r, oi_nxt;

  logic                sq_start, sq_done, dv_start, dv_done;
  logic [LEN_W-1:0]    len;
  div_lane_t [1:0]     dres;
  logic [SQ_W-1:0]     rad;
  logic                emit;

  assign rad      = sx_r + sy_r;
  assign sq_start = (state_r == S_SUM);
  assign dv_start = (state_r == S_QSTART);

  pms_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(rad),
    .root(len), .done(sq_done)
  );

  pms_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend({ay_r, ax_r}),
    .divisor(n_r), .res(dres), .done(dv_done)
  );

  logic              in_fire, can_out;
  logic              np, npass, vip_full, edge_ok;
  logic [DIF_W-1:0]  dx, dy;
  logic [LEN_W:0]    two_len;
  logic [SATW-1:0]   sat_lim;
  logic [SATW+1:0]   ntrial;
  logic [SEG_W:0]    rxs, rys;
  logic              cx, cy;

  always_comb begin
    state_nxt = state_r;  grid_nxt = grid_r;
    prev_x_nxt = prev_x_r; prev_y_nxt = prev_y_r;
    vip_nxt = vip_r; pc_nxt = pc_r; pa_nxt = pa_r; me_nxt = me_r; st_nxt = st_r;
    ax_nxt = ax_r; ay_nxt = ay_r; negx_nxt = negx_r; negy_nxt = negy_r;
    px_nxt = px_r; py_nxt = py_r; first_nxt = first_r;
    sx_nxt = sx_r; sy_nxt = sy_r;
    n_nxt = n_r; nq_nxt = nq_r; nrem_nxt = nrem_r; nbit_nxt = nbit_r;
    s_nxt = s_r; qx_nxt = qx_r; qy_nxt = qy_r; rx_nxt = rx_r; ry_nxt = ry_r;
    ox_nxt = ox_r; oy_nxt = oy_r; oi_nxt = oi_r; ol_nxt = ol_r;
    emit = 1'b0;

    in_fire = in_tvalid && in_tready;
    can_out = !ov_r || out_tready;
    np      = in_tuser[0];
    npass   = in_tuser[1];
    dx = {in_tdata[31], in_tdata[31:0]} - {prev_x_r[CRD_W-1], prev_x_r};
    dy = {in_tdata[63], in_tdata[63:32]} - {prev_y_r[CRD_W-1], prev_y_r};
    vip_full = 1'b0;
    edge_ok  = 1'b0;
    two_len  = {len, 1'b0};
    sat_lim  = SATW'(grid_r) * SATW'(MAX_SEGMENTS);
    ntrial   = (SATW+2)'(grid_r) << nbit_r;
    // advance the step quotients by |d|/n each step
    rxs = {1'b0, rx_r} + {1'b0, dres[0].r};
    rys = {1'b0, ry_r} + {1'b0, dres[1].r};
    cx  = (rxs >= {1'b0, n_r});
    cy  = (rys >= {1'b0, n_r});

    if (cfg_we) grid_nxt = cfg_wdata;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // start-of-pass and start-of-polyline clear the counts first
          if (npass) begin
            me_nxt = '0; pc_nxt = '0; st_nxt = 1'b0;
          end
          if (np || npass) begin
            vip_nxt = '0; pa_nxt = 1'b0;
          end
          vip_full = (vip_nxt >= VP_W'(MAX_POLY_VERTS));
          if (!vip_full) begin
            if (vip_nxt == VP_W'(1)) begin
              pa_nxt = (pc_nxt < PC_W'(MAX_OBSTACLES));
              if (pa_nxt) pc_nxt = pc_nxt + 1'b1;
            end
            edge_ok = (vip_nxt != '0) && pa_nxt && !st_nxt && (dx != '0 || dy != '0);
            first_nxt = (vip_nxt == VP_W'(1));
            px_nxt = prev_x_r; py_nxt = prev_y_r;
            negx_nxt = dx[DIF_W-1]; negy_nxt = dy[DIF_W-1];
            ax_nxt = dx[DIF_W-1] ? DIF_W'(-dx) : dx;
            ay_nxt = dy[DIF_W-1] ? DIF_W'(-dy) : dy;
            prev_x_nxt = in_tdata[31:0];
            prev_y_nxt = in_tdata[63:32];
            vip_nxt = vip_nxt + 1'b1;
            if (edge_ok) state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        sx_nxt = ax_r * ax_r;
        sy_nxt = ay_r * ay_r;
        state_nxt = S_SUM;
      end
      S_SUM: state_nxt = S_ROOT;
      S_ROOT: begin
        if (sq_done) begin
          if (grid_r == '0 || SATW'(two_len) >= sat_lim) begin
            n_nxt = SEG_W'(MAX_SEGMENTS);
            state_nxt = S_QSTART;
          end else begin
            nrem_nxt = two_len;
            nq_nxt   = '0;
            nbit_nxt = NB_W'(SEG_W - 1);
            state_nxt = S_NDIV;
          end
        end
      end
      S_NDIV: begin
        if ((SATW+2)'(nrem_r) >= ntrial) begin
          nrem_nxt = (LEN_W+1)'((SATW+2)'(nrem_r) - ntrial);
          nq_nxt   = nq_r | (SEG_W'(1) << nbit_r);
        end
        if (nbit_r == '0) begin
          n_nxt = (nq_nxt == '0) ? SEG_W'(1) : nq_nxt;
          state_nxt = S_QSTART;
        end else begin
          nbit_nxt = nbit_r - 1'b1;
        end
      end
      S_QSTART: state_nxt = S_QDIV;
      S_QDIV: begin
        if (dv_done) begin
          qx_nxt = '0; qy_nxt = '0; rx_nxt = '0; ry_nxt = '0; s_nxt = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_out) begin
          if (s_r == '0 && !first_r) begin
            s_nxt = s_r + 1'b1;
          end else if (me_r >= MK_W'(MAX_MARKERS)) begin
            st_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            emit   = 1'b1;
            ox_nxt = px_r + (negx_r ? CRD_W'(-qx_r) : qx_r[CRD_W-1:0]);
            oy_nxt = py_r + (negy_r ? CRD_W'(-qy_r) : qy_r[CRD_W-1:0]);
            oi_nxt = me_r[IDX_W-1:0];
            me_nxt = me_r + 1'b1;
            ol_nxt = 1'b0;
            s_nxt  = s_r + 1'b1;
            if (s_r == n_r) begin
              ol_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (me_r == MK_W'(MAX_MARKERS - 1)) begin
              // next marker would cross the limit: stop the pass here
              ol_nxt = 1'b1;
              st_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          if (!(me_r >= MK_W'(MAX_MARKERS) && !(s_r == '0 && !first_r))) begin
            rx_nxt = cx ? SEG_W'(rxs - {1'b0, n_r}) : rxs[SEG_W-1:0];
            ry_nxt = cy ? SEG_W'(rys - {1'b0, n_r}) : rys[SEG_W-1:0];
            qx_nxt = qx_r + dres[0].q + DIF_W'(cx);
            qy_nxt = qy_r + dres[1].q + DIF_W'(cy);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ov_nxt = (ov_r && !out_tready) || emit;
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt; ay_r <= ay_nxt; negx_r <= negx_nxt; negy_r <= negy_nxt;
    px_r <= px_nxt; py_r <= py_nxt; first_r <= first_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt;
    n_r <= n_nxt; nq_r <= nq_nxt; nrem_r <= nrem_nxt; nbit_r <= nbit_nxt;
    s_r <= s_nxt; qx_r <= qx_nxt; qy_r <= qy_nxt; rx_r <= rx_nxt; ry_r <= ry_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; oi_r <= oi_nxt; ol_r <= ol_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      grid_r <= GRID_RESET;
      prev_x_r <= '0; prev_y_r <= '0;
      vip_r <= '0; pc_r <= '0; pa_r <= 1'b0; me_r <= '0; st_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grid_r <= grid_nxt;
      prev_x_r <= prev_x_nxt; prev_y_r <= prev_y_nxt;
      vip_r <= vip_nxt; pc_r <= pc_nxt; pa_r <= pa_nxt; me_r <= me_nxt; st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0000, oi_r, oy_r, ox_r};
  assign out_tlast  = ol_r;

  `PMS_ASSERT(a_mk_bound, clk, rst_n, me_r <= MK_W'(MAX_MARKERS))
  `PMS_ASSERT(a_vip_bound, clk, rst_n, vip_r <= VP_W'(MAX_POLY_VERTS))
  `PMS_ASSERT(a_pc_bound, clk, rst_n, pc_r <= PC_W'(MAX_OBSTACLES))
  `PMS_ASSERT(a_n_range, clk, rst_n, state_r == S_EMIT |-> n_r != '0)
  `PMS_ASSERT(a_last_idle, clk, rst_n, emit && ol_nxt |=> state_r == S_IDLE && out_tvalid)
endmodule

### rtl/pms_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module pms_sqrt
  import pms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SQ_W-1:0]  radicand,
  output logic [LEN_W-1:0] root,
  output logic             done
);
  localparam int REM_W = LEN_W + 2;
  localparam int CNT_W = $clog2(LEN_W + 1);

  logic [SQ_W-1:0]  rad_r;
  logic [REM_W-1:0] rem_r;
  logic [LEN_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r, done_r;
  logic [REM_W+1:0] t, trial;
  logic             take;

  always_comb begin
    t     = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    take  = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= take ? REM_W'(t - trial) : t[REM_W-1:0];
      root_r <= {root_r[LEN_W-2:0], take};
    end
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(LEN_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;
  assign done = done_r;
endmodule

### rtl/pms_div.sv
// Two-lane restoring divider: |dx| and |dy| by the segment count.
module pms_div
  import pms_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0][DIF_W-1:0]       dividend,
  input  logic [SEG_W-1:0]            divisor,
  output div_lane_t [1:0]             res,
  output logic                        done
);
  localparam int CNT_W = $clog2(DIF_W + 1);

  logic [1:0][DIF_W-1:0] num_r;
  logic [1:0][SEG_W-1:0] rem_r;
  logic [SEG_W-1:0]      d_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  run_r, done_r;
  logic [1:0][SEG_W:0]   t;
  logic [1:0]            take;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t[i]    = {rem_r[i], num_r[i][DIF_W-1]};
      take[i] = (t[i] >= {1'b0, d_r});
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (run_r) begin
      for (int i = 0; i < 2; i++) begin
        num_r[i] <= {num_r[i][DIF_W-2:0], take[i]};
        rem_r[i] <= take[i] ? SEG_W'(t[i] - {1'b0, d_r}) : t[i][SEG_W-1:0];
      end
    end
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DIF_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      res[i].q = num_r[i];
      res[i].r = rem_r[i];
    end
  end
  assign done = done_r;
endmodule
